// File: rtl/core/aia_pkg.sv
package aia_pkg;

  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int ADDR_W = 32;
  localparam int ACC_W  = ADDR_W + 3;

  localparam int MAX_SPINORS_DEFAULT = 256;

  localparam logic [CNT_W-1:0]  CNT_RESET = 9'd256;
  localparam logic [ADDR_W-1:0] INV3      = 32'hAAAA_AAAB;

  localparam logic REG_SPINOR_COUNT = 1'b0;
  localparam logic REG_LAYOUT_MODE  = 1'b1;

  typedef struct packed {
    logic err;
    logic zero;
    logic neg;
    logic conj;
    logic dense;
  } flag_t;

  typedef struct packed {
    flag_t            flags;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] m;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] q;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] rx;
    logic [IDX_W-1:0] sx;
    logic [IDX_W-1:0] dq;
  } ord_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// File: rtl/core/aia_order.sv
module aia_order (
  input  logic                       clk,
  input  logic                       en,
  input  logic [aia_pkg::CNT_W-1:0]  n,
  input  logic                       dense_mode,
  input  logic [aia_pkg::IDX_W-1:0]  idx_p,
  input  logic [aia_pkg::IDX_W-1:0]  idx_q,
  input  logic [aia_pkg::IDX_W-1:0]  idx_r,
  input  logic [aia_pkg::IDX_W-1:0]  idx_s,
  output aia_pkg::ord_t              ord
);
  import aia_pkg::*;

  ord_t ord_next;

  always_comb begin
    logic             swap_pq;
    logic             swap_rs;
    logic             swap_pair;
    logic             err;
    logic             zero;
    logic [IDX_W-1:0] lo_pq;
    logic [IDX_W-1:0] hi_pq;
    logic [IDX_W-1:0] lo_rs;
    logic [IDX_W-1:0] hi_rs;
    logic [IDX_W-1:0] sp;
    logic [IDX_W-1:0] sq;
    logic [IDX_W-1:0] sr;
    logic [IDX_W-1:0] ss;
    err = ({1'b0, idx_p} >= n) || ({1'b0, idx_q} >= n) ||
          ({1'b0, idx_r} >= n) || ({1'b0, idx_s} >= n);
    zero = !err && !dense_mode && ((idx_p == idx_q) || (idx_r == idx_s));
    swap_pq = idx_p > idx_q;
    swap_rs = idx_r > idx_s;
    lo_pq = swap_pq ? idx_q : idx_p;
    hi_pq = swap_pq ? idx_p : idx_q;
    lo_rs = swap_rs ? idx_s : idx_r;
    hi_rs = swap_rs ? idx_r : idx_s;
    swap_pair = lo_pq > lo_rs;
    sp = swap_pair ? lo_rs : lo_pq;
    sq = swap_pair ? hi_rs : hi_pq;
    sr = swap_pair ? lo_pq : lo_rs;
    ss = swap_pair ? hi_pq : hi_rs;

    ord_next.flags.err   = err;
    ord_next.flags.zero  = zero;
    ord_next.flags.dense = !err && dense_mode;
    ord_next.flags.neg   = !err && !dense_mode && !zero && (swap_pq ^ swap_rs);
    ord_next.flags.conj  = !err && !dense_mode && !zero && swap_pair;
    ord_next.n  = n;
    ord_next.m  = n - {1'b0, sp};
    ord_next.p  = idx_p;
    ord_next.q  = idx_q;
    ord_next.r  = idx_r;
    ord_next.s  = idx_s;
    ord_next.rx = sr - sp;
    ord_next.sx = ss - sp;
    ord_next.dq = sq - sp - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ord <= ord_next;
    end
  end

endmodule

// File: rtl/core/aia_tetra.sv
module aia_tetra (
  input  logic                        clk,
  input  aia_pkg::stage_en_t          en,
  input  logic [aia_pkg::CNT_W-1:0]   x,
  output logic [aia_pkg::ADDR_W-1:0]  sum
);
  import aia_pkg::*;

  logic [17:0]       lo_prod;
  logic [19:0]       hi_prod;
  logic [ACC_W-1:0]  full;
  logic [37:0]       full_next;
  logic [17:0]       lo_next;
  logic [19:0]       hi_next;
  logic [ADDR_W-1:0] sum_next;

  assign lo_next   = ({9'b0, x} - 18'd1) * {9'b0, x};
  assign hi_next   = ({11'b0, x} + 20'd1) * ({11'b0, x} * 20'd3 - 20'd2);
  assign full_next = {20'b0, lo_prod} * {18'b0, hi_prod};
  assign sum_next  = full[ACC_W-1:3] * INV3;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      lo_prod <= lo_next;
      hi_prod <= hi_next;
    end
    if (en.s3) begin
      full <= full_next[ACC_W-1:0];
    end
    if (en.s4) begin
      sum <= sum_next;
    end
  end

endmodule

// File: rtl/core/aia_dense.sv
module aia_dense (
  input  logic                        clk,
  input  aia_pkg::stage_en_t          en,
  input  aia_pkg::ord_t               ord,
  output logic [aia_pkg::ADDR_W-1:0]  address
);
  import aia_pkg::*;

  logic [17:0]      h1;
  logic [26:0]      h2;
  logic [CNT_W-1:0] n2;
  logic [CNT_W-1:0] n3;
  logic [IDX_W-1:0] q2;
  logic [IDX_W-1:0] s2;
  logic [IDX_W-1:0] s3;
  logic [17:0]      h1_next;
  logic [26:0]      h2_next;
  logic [31:0]      h3_next;

  assign h1_next = {9'b0, ord.n} * {10'b0, ord.p} + {10'b0, ord.r};
  assign h2_next = {9'b0, h1} * {18'b0, n2} + {19'b0, q2};
  assign h3_next = {5'b0, h2} * {23'b0, n3} + {24'b0, s3};

  always_ff @(posedge clk) begin
    if (en.s2) begin
      h1 <= h1_next;
      n2 <= ord.n;
      q2 <= ord.q;
      s2 <= ord.s;
    end
    if (en.s3) begin
      h2 <= h2_next;
      n3 <= n2;
      s3 <= s2;
    end
    if (en.s4) begin
      address <= h3_next;
    end
  end

endmodule

// File: rtl/core/antisym_integral_address_unit.sv
// channel   dir  width  contents
// s_axis    in   32     tdata: idx_p, idx_q, idx_r, idx_s
// m_axis    out  32+4   tdata: address; tuser: negate, conjugate, is_zero, index_error
// cfg       in   1+9    cfg_index 0 spinor_count, 1 layout_mode
//
// One transfer per cycle sustained while m_axis_tready stays high; an input
// transfer reaches m_axis through the multiplier chain of the block-offset sum
// (product, product, reciprocal product, final add).
// rst is synchronous: it empties all five stages and loads spinor_count 256,
// layout_mode 0. Each stage advances when it is empty or its successor moves,
// so an input is taken while the output holds an untaken result if a stage is empty.
module antisym_integral_address_unit #(
  parameter int MAX_SPINORS = aia_pkg::MAX_SPINORS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // idx_p, idx_q, idx_r, idx_s
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [aia_pkg::ADDR_W-1:0]  m_axis_tdata,  // address
  output logic [3:0]                  m_axis_tuser,  // negate, conjugate, is_zero, index_error
  input  logic                        cfg_wen,
  input  logic                        cfg_index,
  input  logic [aia_pkg::CNT_W-1:0]   cfg_data
);
  import aia_pkg::*;

  localparam logic [10:0] MAX_W = 11'(MAX_SPINORS);

  logic [CNT_W-1:0]  spinor_count;
  logic              layout_mode;
  logic [CNT_W-1:0]  n_eff;

  logic              v1, v2, v3, v4, v5;
  logic              en1, en5;
  stage_en_t         en;
  ord_t              ord;
  flag_t             f2, f3, f4;

  logic [16:0]       tri_m;
  logic [16:0]       mrx;
  logic [15:0]       trx;
  logic [IDX_W-1:0]  sx2;
  logic [IDX_W-1:0]  dq2;
  logic [24:0]       offp;
  logic [ADDR_W-1:0] irs;
  logic [ADDR_W-1:0] part;
  logic [ADDR_W-1:0] bsum_n;
  logic [ADDR_W-1:0] bsum_m;
  logic [ADDR_W-1:0] dense_addr;

  logic [17:0]       tri_full;
  logic [16:0]       trx_full;
  logic [ADDR_W-1:0] address_next;

  logic [ADDR_W-1:0] address;
  logic              negate, conjugate, is_zero, index_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      spinor_count <= CNT_RESET;
      layout_mode  <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SPINOR_COUNT: spinor_count <= cfg_data;
        REG_LAYOUT_MODE:  layout_mode  <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  assign n_eff = ({2'b0, spinor_count} > MAX_W) ? MAX_W[CNT_W-1:0] : spinor_count;

  assign en5    = !v5 || m_axis_tready;
  assign en.s4  = !v4 || en5;
  assign en.s3  = !v3 || en.s4;
  assign en.s2  = !v2 || en.s3;
  assign en1    = !v1 || en.s2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1)   v1 <= s_axis_tvalid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
      if (en5)   v5 <= v4;
    end
  end

  aia_order u_order (
    .clk        (clk),
    .en         (en1),
    .n          (n_eff),
    .dense_mode (layout_mode),
    .idx_p      (s_axis_tdata[7:0]),
    .idx_q      (s_axis_tdata[15:8]),
    .idx_r      (s_axis_tdata[23:16]),
    .idx_s      (s_axis_tdata[31:24]),
    .ord        (ord)
  );

  aia_tetra u_tetra_n (
    .clk (clk),
    .en  (en),
    .x   (ord.n),
    .sum (bsum_n)
  );

  aia_tetra u_tetra_m (
    .clk (clk),
    .en  (en),
    .x   (ord.m),
    .sum (bsum_m)
  );

  aia_dense u_dense (
    .clk     (clk),
    .en      (en),
    .ord     (ord),
    .address (dense_addr)
  );

  assign tri_full = {9'b0, ord.m} * ({9'b0, ord.m} - 18'd1);
  assign trx_full = ({9'b0, ord.rx} + 17'd1) * ({9'b0, ord.rx} + 17'd2);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      f2    <= ord.flags;
      tri_m <= tri_full[17:1];
      mrx   <= {8'b0, ord.m} * {9'b0, ord.rx};
      trx   <= trx_full[16:1];
      sx2   <= ord.sx;
      dq2   <= ord.dq;
    end
    if (en.s3) begin
      f3   <= f2;
      offp <= {17'b0, dq2} * {8'b0, tri_m};
      irs  <= {15'b0, mrx} + {24'b0, sx2} - {16'b0, trx};
    end
    if (en.s4) begin
      f4   <= f3;
      part <= {7'b0, offp} + irs;
    end
  end

  always_comb begin
    if (f4.err || f4.zero) begin
      address_next = '0;
    end else if (f4.dense) begin
      address_next = dense_addr;
    end else begin
      address_next = bsum_n - bsum_m + part;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      address     <= address_next;
      negate      <= f4.neg;
      conjugate   <= f4.conj;
      is_zero     <= f4.zero;
      index_error <= f4.err;
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = address;
  assign m_axis_tuser  = {index_error, is_zero, conjugate, negate};

  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(index_error && (is_zero || negate || conjugate)))
    else $error("index error combined with another flag");

  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (index_error || is_zero) |-> address == '0)
    else $error("nonzero address on error or zero result");

  a_zero_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && is_zero |-> !negate && !conjugate)
    else $error("sign flags on a vanishing integral");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && v1 && v2 && v3 && v4)
    else $error("input held off while the pipeline has room");

endmodule

// File: tb/aia_address_checker.sv
`timescale 1ns / 100ps

module aia_address_checker #(
  parameter int MAX_SPINORS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // idx_p, idx_q, idx_r, idx_s
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [aia_pkg::ADDR_W-1:0] m_axis_tdata,  // address
  input  logic [3:0]                 m_axis_tuser,  // negate, conjugate, is_zero, index_error
  input  logic                       cfg_wen,
  input  logic                       cfg_index,
  input  logic [aia_pkg::CNT_W-1:0]  cfg_data,
  output int                         fail_count,
  output int                         pending
);

  import aia_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              negate;
    logic              conjugate;
    logic              is_zero;
    logic              index_error;
  } addr_result_t;

  addr_result_t     lookup_q[$];
  logic [CNT_W-1:0] spinor_count;
  logic             layout_dense;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic longint unsigned pair_count(longint unsigned m);
    return (m == 0) ? 0 : m * (m - 1) / 2;
  endfunction

  // elements held by the pair blocks whose first index leaves m spinors at or above it
  function automatic longint unsigned block_volume(longint unsigned m);
    longint unsigned s1, s2;
    s1 = m * (m + 1) / 2;
    s2 = m * (m + 1) * (2 * m + 1) / 6;
    return (s1 * s1 - 2 * s2 + s1) / 2;
  endfunction

  function automatic addr_result_t predict_address(logic [31:0] item);
    longint unsigned n, p, q, r, s, t, m, rx, sx, addr;
    addr_result_t res;
    res = '0;
    n = spinor_count;
    if (n > MAX_SPINORS) n = MAX_SPINORS;
    p = item[7:0];
    q = item[15:8];
    r = item[23:16];
    s = item[31:24];
    if (p >= n || q >= n || r >= n || s >= n) begin
      res.index_error = 1'b1;
    end else if (layout_dense) begin
      addr = n * n * n * p + n * n * r + n * q + s;
      res.address = addr[ADDR_W-1:0];
    end else if (p == q || r == s) begin
      res.is_zero = 1'b1;
    end else begin
      if (p > q) begin
        t = p; p = q; q = t;
        res.negate = ~res.negate;
      end
      if (r > s) begin
        t = r; r = s; s = t;
        res.negate = ~res.negate;
      end
      if (p > r) begin
        t = p; p = r; r = t;
        t = q; q = s; s = t;
        res.conjugate = 1'b1;
      end
      m = n - p;
      rx = r - p;
      sx = s - p;
      addr = block_volume(n) - block_volume(m) + (q - p - 1) * pair_count(m)
             + m * rx + sx - (rx + 1) * (rx + 2) / 2;
      res.address = addr[ADDR_W-1:0];
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    addr_result_t want, got;
    if (rst) begin
      lookup_q.delete();
      spinor_count = CNT_RESET;
      layout_dense = 1'b0;
    end else begin
      if (cfg_wen) begin
        if (cfg_index == REG_SPINOR_COUNT) spinor_count = cfg_data;
        else layout_dense = cfg_data[0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.address = m_axis_tdata;
        got.negate = m_axis_tuser[0];
        got.conjugate = m_axis_tuser[1];
        got.is_zero = m_axis_tuser[2];
        got.index_error = m_axis_tuser[3];
        if (lookup_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transfer: expected none, actual %0h/%0h",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = lookup_q.pop_front();
          compare_field("address", want.address, got.address);
          compare_field("negate", want.negate, got.negate);
          compare_field("conjugate", want.conjugate, got.conjugate);
          compare_field("is_zero", want.is_zero, got.is_zero);
          compare_field("index_error", want.index_error, got.index_error);
        end
      end
      if (s_axis_tvalid && s_axis_tready) lookup_q.push_back(predict_address(s_axis_tdata));
    end
    pending = lookup_q.size();
  end

endmodule

// File: tb/antisym_integral_address_unit_test.sv
`timescale 1ns / 100ps

module antisym_integral_address_unit_test;

  import aia_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 10;
  // spinor count per phase: -1 any legal count, -2 a small one
  localparam int PH_COUNT[PHASES] = '{256, 256, 17, 2, -1, 256, 511, -2, 128, -1};
  localparam bit PH_DENSE[PHASES] = '{0, 1, 0, 0, 1, 0, 0, 0, 1, 0};
  localparam int PH_TX[PHASES]    = '{0, 81, 0, 28, 0, 28, 0, 81, 28, 0};
  localparam int PH_RX[PHASES]    = '{0, 0, 81, 28, 0, 28, 81, 0, 28, 0};
  localparam int PH_ITEMS[PHASES] = '{250, 150, 200, 100, 150, 250, 100, 200, 150, 150};

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;   // idx_p, idx_q, idx_r, idx_s
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [ADDR_W-1:0] m_axis_tdata;   // address
  logic [3:0]        m_axis_tuser;   // negate, conjugate, is_zero, index_error
  logic              cfg_wen;
  logic              cfg_index;
  logic [CNT_W-1:0]  cfg_data;

  int fail_count;
  int pending;
  int tx_idle_pct;
  int rx_stall_pct;
  bit hold_req;
  int cur_count;

  antisym_integral_address_unit uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  aia_address_checker checker_inst (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("antisym_integral_address_unit regression: fail");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] p, input logic [7:0] q,
                           input logic [7:0] r, input logic [7:0] s);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {s, r, q, p};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // drop valid and wait until every lookup has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_config(input int count, input logic dense);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= REG_SPINOR_COUNT;
    cfg_data <= count[CNT_W-1:0];
    @(posedge clk);
    cfg_index <= REG_LAYOUT_MODE;
    cfg_data <= {{(CNT_W-1){1'b0}}, dense};
    @(posedge clk);
    cfg_wen <= 1'b0;
    cur_count = count;
  endtask

  function automatic logic [7:0] pick_index(int lim);
    if (lim == 0 || $urandom_range(99) < 12) return 8'($urandom_range(255));
    return 8'($urandom_range(lim - 1));
  endfunction

  task automatic send_random(input int items);
    int lim;
    logic [7:0] p, q, r, s;
    lim = (cur_count > 256) ? 256 : cur_count;
    repeat (items) begin
      p = pick_index(lim);
      q = pick_index(lim);
      r = pick_index(lim);
      s = pick_index(lim);
      if ($urandom_range(99) < 4) q = p;
      if ($urandom_range(99) < 4) s = r;
      send_item(p, q, r, s);
    end
  endtask

  initial begin
    int count;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_wen = 1'b0;
    cfg_index = REG_SPINOR_COUNT;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b0;
    cur_count = 256;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // packed layout at reset settings: ordering, swaps, zeros, extremes
    send_item(0, 1, 0, 1);
    send_item(1, 0, 0, 1);
    send_item(0, 1, 1, 0);
    send_item(1, 0, 1, 0);
    send_item(2, 3, 0, 1);
    send_item(3, 2, 1, 0);
    send_item(5, 5, 1, 2);
    send_item(1, 2, 7, 7);
    send_item(254, 255, 254, 255);
    send_item(0, 255, 0, 255);
    send_item(255, 255, 255, 255);
    drain();
    // out-of-range indices, error over zero
    write_config(10, 1'b0);
    send_item(10, 0, 1, 2);
    send_item(0, 10, 1, 2);
    send_item(0, 1, 10, 2);
    send_item(0, 1, 2, 10);
    send_item(10, 10, 3, 3);
    send_item(9, 8, 7, 6);
    drain();
    // dense layout, address from zero up to its largest value
    write_config(256, 1'b1);
    send_item(255, 255, 255, 255);
    send_item(0, 0, 0, 0);
    send_item(1, 2, 3, 4);
    drain();
    // count above the maximum saturates
    write_config(300, 1'b0);
    send_item(255, 254, 0, 1);
    drain();
    write_config(0, 1'b0);
    send_item(0, 0, 0, 0);
    drain();
    write_config(1, 1'b0);
    send_item(0, 0, 0, 0);
    drain();
    write_config(2, 1'b0);
    send_item(0, 1, 1, 0);
    send_item(1, 0, 0, 1);

    for (int i = 0; i < PHASES; i++) begin
      if (PH_COUNT[i] == -1) count = $urandom_range(256, 2);
      else if (PH_COUNT[i] == -2) count = $urandom_range(64, 2);
      else count = PH_COUNT[i];
      drain();
      write_config(count, PH_DENSE[i]);
      tx_idle_pct = PH_TX[i];
      rx_stall_pct = PH_RX[i];
      if (i == 4) hold_req = 1'b1;
      send_random(PH_ITEMS[i]);
    end

    s_axis_tvalid <= 1'b0;
    rx_stall_pct = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("antisym_integral_address_unit regression: pass");
    end else begin
      $display("antisym_integral_address_unit regression: fail");
    end
    $finish;
  end

endmodule
